### src/mssg_pkg.sv
// Shared types, constants and the sine table generator for the setpoint generator.
package mssg_pkg;

  // Configuration register indexes
  typedef logic [2:0] cfg_index_t;
  typedef enum logic [2:0] {
    REG_SEGMENT_TYPE,
    REG_BASE_LEFT,
    REG_BASE_RIGHT,
    REG_PARAM_A,
    REG_PARAM_B,
    REG_PARAM_C,
    REG_START_TICK
  } reg_index_t;

  // Segment kinds
  typedef enum logic [1:0] {
    SEG_IDLE,
    SEG_CONST,
    SEG_RAMP,
    SEG_SINE
  } seg_t;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_1000_SHIFT for any 32-bit x
  localparam logic [28:0] RECIP_1000       = 29'd274877907;
  localparam int          RECIP_1000_SHIFT = 38;
  // floor(x / 15625) == (x * RECIP_15625) >> 44 for any 30-bit x
  localparam logic [30:0] RECIP_15625      = 31'd1125899907;
  localparam int          RECIP_15625_SHIFT = 44;

  localparam logic [31:0] ONE_MILLION = 32'd1000000;
  localparam logic [31:0] ONE_THOUSAND = 32'd1000;

  // Q15 sine of a first-quadrant binary angle u (0..16384), Taylor series in Q30
  function automatic logic [14:0] quad_sine(input int unsigned u);
    logic [63:0] one;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    one = 64'd1 << 30;
    x   = (64'(u) * 64'd3373259426) >> 15;
    x2  = (x * x) >> 30;
    t   = one;
    t   = one - ((x2 * t) >> 30) / 64'd110;
    t   = one - ((x2 * t) >> 30) / 64'd72;
    t   = one - ((x2 * t) >> 30) / 64'd42;
    t   = one - ((x2 * t) >> 30) / 64'd20;
    t   = one - ((x2 * t) >> 30) / 64'd6;
    s   = (x * t) >> 30;
    s   = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

endpackage

### src/motion_segment_setpoint_generator.sv
// Top level of the motion segment setpoint generator: ten-stage pipeline.
//
// Usage
//   in_*  : one request per control tick. in_tdata carries now_tick, in_tuser
//           carries in_motion. A request with in_motion clear is taken and
//           produces no result.
//   out_* : one result per moving tick, out_tdata = {drive_right, drive_left}.
//   cfg_* : register writes (index, data), always ready. Write only while no
//           request is in flight.
// Timing
//   Ten register stages, the first loaded by the accepting edge; a result is
//   valid once its request reaches the tenth. One request per cycle is kept
//   up while out_tready is high; the depth is set by the chain of reciprocal
//   multiplies (divide by 1000 and 1e6), table read and amplitude multiply.
// Reset
//   rst_n clears all stage valid bits and zeroes the configuration registers.
// Stall
//   When out_tready is low, the result holds in the output register and empty
//   stages ahead of it keep filling; in_tready drops only once every stage
//   holds a pending result. Nothing is lost or repeated.
module motion_segment_setpoint_generator #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [31:0] now_tick
  input  logic [31:0]           in_tdata,
  // in_tuser: [0] in_motion
  input  logic [0:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: [15:0] drive_left, [31:16] drive_right
  output logic [31:0]           out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  mssg_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]           cfg_data
);
  import mssg_pkg::*;

  localparam int NSTG   = 10;
  localparam int TB     = SINE_TABLE_BITS;
  localparam int QDEPTH = 1 << (TB - 2);
  localparam int ASHIFT = 16 - TB;
  localparam logic [TB-2:0] QTOP = {1'b1, {(TB - 2){1'b0}}};

  // Configuration registers
  seg_t        segment_type_r;
  logic [15:0] base_left_r;
  logic [15:0] base_right_r;
  logic [15:0] param_a_r;
  logic [15:0] param_b_r;
  logic [15:0] param_c_r;
  logic [31:0] start_tick_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_type_r <= SEG_IDLE;
      base_left_r    <= '0;
      base_right_r   <= '0;
      param_a_r      <= '0;
      param_b_r      <= '0;
      param_c_r      <= '0;
      start_tick_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEGMENT_TYPE: segment_type_r <= seg_t'(cfg_data[1:0]);
        REG_BASE_LEFT:    base_left_r    <= cfg_data[15:0];
        REG_BASE_RIGHT:   base_right_r   <= cfg_data[15:0];
        REG_PARAM_A:      param_a_r      <= cfg_data[15:0];
        REG_PARAM_B:      param_b_r      <= cfg_data[15:0];
        REG_PARAM_C:      param_c_r      <= cfg_data[15:0];
        REG_START_TICK:   start_tick_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Magnitudes and signs of the rate/frequency registers
  logic [15:0] amag;
  logic [15:0] bmag;
  logic        aneg;
  logic        bneg;
  assign aneg = param_a_r[15];
  assign bneg = param_b_r[15];
  assign amag = aneg ? (~param_a_r + 16'd1) : param_a_r;
  assign bmag = bneg ? (~param_b_r + 16'd1) : param_b_r;

  // Stage valid bits and load enables; empty stages take data even when stalled
  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] stage_en;

  always_comb begin
    stage_en[NSTG-1] = !valid_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  assign valid_nxt = {valid_r[NSTG-2:0], in_tvalid & in_tuser[0]};
  assign in_tready = stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (stage_en[k]) begin
          valid_r[k] <= valid_nxt[k];
        end
      end
    end
  end

  // Stage 1: elapsed ticks, unsigned and as signed magnitude
  logic [31:0] diff;
  logic [31:0] s1_diff_r;
  logic [31:0] s1_emag_r;
  logic        s1_eneg_r;
  assign diff = in_tdata - start_tick_r;

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      s1_diff_r <= diff;
      s1_emag_r <= diff[31] ? (~diff + 32'd1) : diff;
      s1_eneg_r <= diff[31];
    end
  end

  // Stage 2: whole millions of elapsed ticks, whole thousands of |elapsed|
  logic [60:0] dh_prod;
  logic [60:0] qe_prod;
  logic [12:0] s2_dh_r;
  logic [21:0] s2_qe_r;
  logic [31:0] s2_diff_r;
  logic [31:0] s2_emag_r;
  logic        s2_eneg_r;
  assign dh_prod = {35'd0, s1_diff_r[31:6]} * {30'd0, RECIP_15625};
  assign qe_prod = {29'd0, s1_emag_r} * {32'd0, RECIP_1000};

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      s2_dh_r   <= dh_prod[RECIP_15625_SHIFT +: 13];
      s2_qe_r   <= qe_prod[RECIP_1000_SHIFT +: 22];
      s2_diff_r <= s1_diff_r;
      s2_emag_r <= s1_emag_r;
      s2_eneg_r <= s1_eneg_r;
    end
  end

  // Stage 3: remainders of the two divisions
  logic [31:0] dl_full;
  logic [31:0] re_full;
  logic [19:0] s3_dl_r;
  logic [9:0]  s3_re_r;
  logic [15:0] s3_qe_r;
  logic        s3_eneg_r;
  assign dl_full = s2_diff_r - ({19'd0, s2_dh_r} * ONE_MILLION);
  assign re_full = s2_emag_r - ({10'd0, s2_qe_r} * ONE_THOUSAND);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      s3_dl_r   <= dl_full[19:0];
      s3_re_r   <= re_full[9:0];
      s3_qe_r   <= s2_qe_r[15:0];
      s3_eneg_r <= s2_eneg_r;
    end
  end

  // Stage 4: phase product |b| * (diff mod 1e6); ramp partial products
  logic [35:0] v_full;
  logic [25:0] ya_full;
  logic [25:0] yb_full;
  logic [34:0] s4_v_r;
  logic [24:0] s4_ya_r;
  logic [24:0] s4_yb_r;
  logic [15:0] s4_pqa_r;
  logic [15:0] s4_pqb_r;
  logic        s4_eneg_r;
  assign v_full  = {20'd0, bmag} * {16'd0, s3_dl_r};
  assign ya_full = {10'd0, amag} * {16'd0, s3_re_r};
  assign yb_full = {10'd0, bmag} * {16'd0, s3_re_r};

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      s4_v_r    <= v_full[34:0];
      s4_ya_r   <= ya_full[24:0];
      s4_yb_r   <= yb_full[24:0];
      s4_pqa_r  <= amag * s3_qe_r;
      s4_pqb_r  <= bmag * s3_qe_r;
      s4_eneg_r <= s3_eneg_r;
    end
  end

  // Stage 5: whole millions of the phase product; ramp remainder quotients
  logic [60:0] rq_prod;
  logic [53:0] fa_prod;
  logic [53:0] fb_prod;
  logic [15:0] s5_rq_r;
  logic [34:0] s5_v_r;
  logic [15:0] s5_fa_r;
  logic [15:0] s5_fb_r;
  logic [15:0] s5_pqa_r;
  logic [15:0] s5_pqb_r;
  logic        s5_eneg_r;
  assign rq_prod = {32'd0, s4_v_r[34:6]} * {30'd0, RECIP_15625};
  assign fa_prod = {29'd0, s4_ya_r} * {25'd0, RECIP_1000};
  assign fb_prod = {29'd0, s4_yb_r} * {25'd0, RECIP_1000};

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      s5_rq_r   <= rq_prod[RECIP_15625_SHIFT +: 16];
      s5_v_r    <= s4_v_r;
      s5_fa_r   <= fa_prod[RECIP_1000_SHIFT +: 16];
      s5_fb_r   <= fb_prod[RECIP_1000_SHIFT +: 16];
      s5_pqa_r  <= s4_pqa_r;
      s5_pqb_r  <= s4_pqb_r;
      s5_eneg_r <= s4_eneg_r;
    end
  end

  // Stage 6: phase product modulo 1e6 (floored); finish ramp outputs
  logic [34:0] rr_full;
  logic [19:0] rr;
  logic [19:0] r_mod;
  logic [15:0] qa_sum;
  logic [15:0] qb_sum;
  logic [15:0] qa_sgn;
  logic [15:0] qb_sgn;
  logic [19:0] s6_r_r;
  logic [15:0] s6_rampl_r;
  logic [15:0] s6_rampr_r;
  assign rr_full = s5_v_r - ({19'd0, s5_rq_r} * {3'd0, ONE_MILLION});
  assign rr      = rr_full[19:0];
  assign r_mod   = (bneg && (rr != 20'd0)) ? (ONE_MILLION[19:0] - rr) : rr;
  assign qa_sum  = s5_pqa_r + s5_fa_r;
  assign qb_sum  = s5_pqb_r + s5_fb_r;
  assign qa_sgn  = (aneg ^ s5_eneg_r) ? (~qa_sum + 16'd1) : qa_sum;
  assign qb_sgn  = (bneg ^ s5_eneg_r) ? (~qb_sum + 16'd1) : qb_sum;

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      s6_r_r     <= r_mod;
      s6_rampl_r <= qa_sgn + base_left_r;
      s6_rampr_r <= qb_sgn + base_right_r;
    end
  end

  // Stage 7: binary angle = floor(r * 65536 / 1e6)
  logic [60:0] a_prod;
  logic [15:0] s7_a_r;
  logic [15:0] s7_rampl_r;
  logic [15:0] s7_rampr_r;
  assign a_prod = {31'd0, s6_r_r, 10'd0} * {30'd0, RECIP_15625};

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      s7_a_r     <= a_prod[RECIP_15625_SHIFT +: 16];
      s7_rampl_r <= s6_rampl_r;
      s7_rampr_r <= s6_rampr_r;
    end
  end

  // Quarter-wave sine table, built at elaboration
  logic [14:0] rom_w [QDEPTH+1];
  for (genvar g = 0; g <= QDEPTH; g++) begin : g_rom
    localparam int unsigned U = g << ASHIFT;
    localparam logic [14:0] VAL = quad_sine(U);
    assign rom_w[g] = VAL;
  end

  // Stage 8: subtract phase, fold into the first quadrant, read table
  logic [15:0]   ang;
  logic [TB-3:0] k_idx;
  logic [TB-2:0] q_idx;
  logic [14:0]   s8_sin_r;
  logic          s8_neg_r;
  logic [15:0]   s8_rampl_r;
  logic [15:0]   s8_rampr_r;
  assign ang   = s7_a_r - param_c_r;
  assign k_idx = ang[13 -: (TB - 2)];
  assign q_idx = ang[14] ? (QTOP - {1'b0, k_idx}) : {1'b0, k_idx};

  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      s8_sin_r   <= rom_w[q_idx];
      s8_neg_r   <= ang[15];
      s8_rampl_r <= s7_rampl_r;
      s8_rampr_r <= s7_rampr_r;
    end
  end

  // Stage 9: amplitude times signed sine
  logic signed [15:0] sin_s;
  logic signed [31:0] s9_prod_r;
  logic [15:0]        s9_rampl_r;
  logic [15:0]        s9_rampr_r;
  assign sin_s = s8_neg_r ? $signed(~{1'b0, s8_sin_r} + 16'd1) : $signed({1'b0, s8_sin_r});

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      s9_prod_r  <= $signed(param_a_r) * sin_s;
      s9_rampl_r <= s8_rampl_r;
      s9_rampr_r <= s8_rampr_r;
    end
  end

  // Add base in Q15, clip to 0..32767 and truncate
  function automatic logic [15:0] sine_clip(input logic [31:0] prod, input logic [15:0] base);
    logic [32:0] n;
    n = {prod[31], prod} + {base[15], base[15], base, 15'd0};
    if (n[32] || (n == 33'd0)) begin
      return 16'd0;
    end else if (|n[31:30]) begin
      return 16'h7FFF;
    end
    return {1'b0, n[29:15]};
  endfunction

  // Stage 10: select by segment kind into the output register
  logic [15:0] out_l;
  logic [15:0] out_r;
  logic [31:0] s10_data_r;

  always_comb begin
    case (segment_type_r)
      SEG_IDLE: begin
        out_l = 16'd0;
        out_r = 16'd0;
      end
      SEG_CONST: begin
        out_l = base_left_r;
        out_r = base_right_r;
      end
      SEG_RAMP: begin
        out_l = s9_rampl_r;
        out_r = s9_rampr_r;
      end
      SEG_SINE: begin
        out_l = sine_clip(s9_prod_r, base_left_r);
        out_r = sine_clip(s9_prod_r, base_right_r);
      end
      default: begin
        out_l = 16'd0;
        out_r = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      s10_data_r <= {out_r, out_l};
    end
  end

  assign out_tdata  = s10_data_r;
  assign out_tvalid = valid_r[NSTG-1];

endmodule
